// ===== rtl/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants for the PHY link supervisor
// Holds the beat layouts, the register index codes, the step codes and the
// clause-22 frame builder.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_PHY_ADDR    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STATUS_REG  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONTROL_VAL = 2'd2;

  localparam logic [4:0]  PHY_ADDR_RST    = 5'd1;
  localparam logic [4:0]  STATUS_REG_RST  = 5'd16;
  localparam logic [15:0] CONTROL_VAL_RST = 16'h1100;

  localparam logic [4:0] REG_BMCR = 5'd0;
  localparam logic [4:0] REG_BMSR = 5'd1;

  localparam int BMSR_LINK_BIT   = 2;
  localparam int STS_LINK_BIT    = 0;
  localparam int STS_SPEED10_BIT = 1;
  localparam int STS_DUPLEX_BIT  = 2;

  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd1;

  // linking sequence steps
  localparam logic [2:0] LS_READ_BMSR   = 3'd0;
  localparam logic [2:0] LS_WAIT_BMSR   = 3'd1;
  localparam logic [2:0] LS_WRITE_BMCR  = 3'd2;
  localparam logic [2:0] LS_READ_STATUS = 3'd3;
  localparam logic [2:0] LS_WAIT_STATUS = 3'd4;
  localparam logic [2:0] LS_DONE        = 3'd5;

  typedef struct packed {
    logic [4:0]  phy_address;
    logic [4:0]  status_reg_address;
    logic [15:0] control_write_value;
  } pls_cfg_t;

  typedef struct packed {
    logic       mode_connected;
    logic [2:0] link_step;
    logic       check_step;
    logic       speed_flag;
    logic       duplex_flag;
    logic       receive_enabled;
  } pls_state_t;

  typedef struct packed {
    logic        poll_receive;
    logic        full_duplex;
    logic        speed_100;
    logic        rx_enable;
    logic        connected;
    logic [31:0] mdio_command;
    logic        command_valid;
  } pls_result_t;

  function automatic logic [31:0] frame_word(input logic [1:0]  op,
                                             input logic [4:0]  phy,
                                             input logic [4:0]  regad,
                                             input logic [15:0] data);
    frame_word = {2'b01, op, phy, regad, 2'b10, data};
  endfunction

endpackage

// ===== rtl/pls_core.sv =====
// ----------------------------------------------------------------------------
// pls_core: link supervision state and per-tick step logic
// Holds the supervisor state and computes the result of the tick in the
// input register; the state advances when that tick moves on.
// ----------------------------------------------------------------------------
module pls_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 mdio_idle,
  input  logic [15:0]          mdio_read_data,
  input  pls_pkg::pls_cfg_t    cfg,
  output pls_pkg::pls_result_t result
);
  import pls_pkg::*;

  pls_state_t st_r;
  pls_state_t st_nxt;
  logic       valid;
  logic [31:0] cmd;
  logic       poll;
  logic       link_ok;

  always_comb begin
    st_nxt  = st_r;
    valid   = 1'b0;
    cmd     = '0;
    poll    = 1'b0;
    link_ok = 1'b1;
    if (!st_r.mode_connected) begin
      unique case (st_r.link_step)
        LS_READ_BMSR: begin
          valid            = 1'b1;
          cmd              = frame_word(OP_READ, cfg.phy_address, REG_BMSR, 16'd0);
          st_nxt.link_step = LS_WAIT_BMSR;
        end
        LS_WAIT_BMSR: begin
          if (mdio_idle) begin
            st_nxt.link_step = mdio_read_data[BMSR_LINK_BIT] ? LS_WRITE_BMCR : LS_READ_BMSR;
          end
        end
        LS_WRITE_BMCR: begin
          valid            = 1'b1;
          cmd              = frame_word(OP_WRITE, cfg.phy_address, REG_BMCR,
                                        cfg.control_write_value);
          st_nxt.link_step = LS_READ_STATUS;
        end
        LS_READ_STATUS: begin
          if (mdio_idle) begin
            valid            = 1'b1;
            cmd              = frame_word(OP_READ, cfg.phy_address,
                                          cfg.status_reg_address, 16'd0);
            st_nxt.link_step = LS_WAIT_STATUS;
          end
        end
        LS_WAIT_STATUS: begin
          if (mdio_idle) begin
            if (mdio_read_data[STS_LINK_BIT]) begin
              st_nxt.speed_flag      = ~mdio_read_data[STS_SPEED10_BIT];
              st_nxt.duplex_flag     = mdio_read_data[STS_DUPLEX_BIT];
              st_nxt.link_step       = LS_DONE;
              st_nxt.mode_connected  = 1'b1;
              st_nxt.receive_enabled = 1'b1;
            end else begin
              st_nxt.link_step = LS_READ_STATUS;
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      if (!st_r.check_step) begin
        valid             = 1'b1;
        cmd               = frame_word(OP_READ, cfg.phy_address, REG_BMSR, 16'd0);
        st_nxt.check_step = 1'b1;
      end else if (mdio_idle) begin
        link_ok           = mdio_read_data[BMSR_LINK_BIT];
        st_nxt.check_step = 1'b0;
      end
      if (!link_ok) begin
        st_nxt.receive_enabled = 1'b0;
        st_nxt.link_step       = LS_READ_BMSR;
        st_nxt.mode_connected  = 1'b0;
      end else begin
        poll = 1'b1;
      end
    end
  end

  always_comb begin
    result.command_valid = valid;
    result.mdio_command  = cmd;
    result.connected     = st_nxt.mode_connected;
    result.rx_enable     = st_nxt.receive_enabled;
    result.speed_100     = st_nxt.speed_flag;
    result.full_duplex   = st_nxt.duplex_flag;
    result.poll_receive  = poll;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/phy_link_supervisor.sv =====
// ----------------------------------------------------------------------------
// phy_link_supervisor: MDIO-driven Ethernet PHY link supervisor
// One polling tick per input beat, one result beat per tick.
//
//   channel | dir | beat content (low bit first)
//   in_     | in  | mdio_idle, mdio_read_data
//   out_    | out | command_valid, mdio_command, connected, rx_enable,
//           |     | speed_100, full_duplex, poll_receive
//   cfg_    | in  | register index, write data (no read-back)
//
// The path is input register, step logic, output register. One beat per
// cycle is sustained while the output is not stalled; the supervisor state
// is updated as the input register hands its tick to the output register.
// Reset clears the state and loads the register defaults; no clearing pass.
// A stalled output holds its beat and stops the input register behind it.
// ----------------------------------------------------------------------------
module phy_link_supervisor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] mdio_idle, [16:1] mdio_read_data, [23:17] zero
  input  logic [pls_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] command_valid, [32:1] mdio_command, [33] connected, [34] rx_enable,
  // [35] speed_100, [36] full_duplex, [37] poll_receive, [39:38] zero
  output logic [pls_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [pls_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pls_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pls_pkg::*;

  pls_cfg_t    cfg_r;
  logic        in_valid_r;
  logic        in_idle_r;
  logic [15:0] in_rdata_r;
  logic        out_valid_r;
  pls_result_t out_data_r;
  pls_result_t result;
  logic        advance;
  logic        step_en;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign step_en   = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phy_address         <= PHY_ADDR_RST;
      cfg_r.status_reg_address  <= STATUS_REG_RST;
      cfg_r.control_write_value <= CONTROL_VAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_PHY_ADDR:    cfg_r.phy_address         <= cfg_wdata[4:0];
        CFG_STATUS_REG:  cfg_r.status_reg_address  <= cfg_wdata[4:0];
        CFG_CONTROL_VAL: cfg_r.control_write_value <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_idle_r  <= in_tdata[0];
      in_rdata_r <= in_tdata[16:1];
    end
  end

  pls_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .mdio_idle      (in_idle_r),
    .mdio_read_data (in_rdata_r),
    .cfg            (cfg_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

// ===== rtl/pls_checker.sv =====
// ----------------------------------------------------------------------------
// pls_checker: port-level checks for the PHY link supervisor
// Watches the result channel and the consistency of its beat fields.
// ----------------------------------------------------------------------------
module pls_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pls_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pls_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out beat changed while stalled");

  a_cmd_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] ? (out_tdata[32:31] == 2'b01 && out_tdata[18:17] == 2'b10)
                                 : (out_tdata[32:1] == 32'd0)))
    else $error("malformed mdio command field");

  a_link_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34] == out_tdata[33]) && (!out_tdata[37] || out_tdata[33]))
    else $error("rx_enable or poll_receive inconsistent with connected");

endmodule

bind phy_link_supervisor pls_checker u_pls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/phy_link_supervisor_test.sv =====
// ----------------------------------------------------------------------------
// phy_link_supervisor_test: self-checking bench for the PHY link supervisor
// Feeds polling ticks (MDIO idle flag and read data) and predicts each result
// beat from a local copy of the link state and registers. The ticks walk the
// linking sequence, link-up, link checks and link loss. Both stream sides
// idle at random, and the output is held off once long enough to fill the
// block. Registers are rewritten between phases, the extremes among them.
// ----------------------------------------------------------------------------
module phy_link_supervisor_test;
  import pls_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = CFG_PHY_ADDR;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  pls_state_t  sup = '0;
  pls_cfg_t    setting = '{PHY_ADDR_RST, STATUS_REG_RST, CONTROL_VAL_RST};
  pls_result_t status_q[$];

  bit gaps_on = 1'b1;
  bit stall_ask = 1'b0;
  bit stall_seen = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  int mismatches = 0;
  int ticks_sent = 0;
  int beats_checked = 0;
  int link_ups = 0;
  int link_losses = 0;
  int settings_used = 1;

  phy_link_supervisor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] mdio_frame(input logic [1:0] op, input logic [4:0] regad,
                                             input logic [15:0] data);
    return {2'b01, op, setting.phy_address, regad, 2'b10, data};
  endfunction

  function automatic pls_result_t advance_supervisor(input logic idle, input logic [15:0] rd);
    pls_result_t r;
    logic        link_ok;
    r = '0;
    link_ok = 1'b1;
    if (!sup.mode_connected) begin
      case (sup.link_step)
        LS_READ_BMSR: begin
          r.command_valid = 1'b1;
          r.mdio_command = mdio_frame(OP_READ, REG_BMSR, 16'h0000);
          sup.link_step = LS_WAIT_BMSR;
        end
        LS_WAIT_BMSR: begin
          if (idle) sup.link_step = rd[BMSR_LINK_BIT] ? LS_WRITE_BMCR : LS_READ_BMSR;
        end
        LS_WRITE_BMCR: begin
          r.command_valid = 1'b1;
          r.mdio_command = mdio_frame(OP_WRITE, REG_BMCR, setting.control_write_value);
          sup.link_step = LS_READ_STATUS;
        end
        LS_READ_STATUS: begin
          if (idle) begin
            r.command_valid = 1'b1;
            r.mdio_command = mdio_frame(OP_READ, setting.status_reg_address, 16'h0000);
            sup.link_step = LS_WAIT_STATUS;
          end
        end
        LS_WAIT_STATUS: begin
          if (idle) begin
            if (rd[STS_LINK_BIT]) begin
              sup.speed_flag = !rd[STS_SPEED10_BIT];
              sup.duplex_flag = rd[STS_DUPLEX_BIT];
              sup.link_step = LS_DONE;
              sup.mode_connected = 1'b1;
              sup.receive_enabled = 1'b1;
              link_ups++;
            end else begin
              sup.link_step = LS_READ_STATUS;
            end
          end
        end
        default: ;
      endcase
    end else begin
      if (!sup.check_step) begin
        r.command_valid = 1'b1;
        r.mdio_command = mdio_frame(OP_READ, REG_BMSR, 16'h0000);
        sup.check_step = 1'b1;
      end else if (idle) begin
        link_ok = rd[BMSR_LINK_BIT];
        sup.check_step = 1'b0;
      end
      if (!link_ok) begin
        sup.receive_enabled = 1'b0;
        sup.link_step = LS_READ_BMSR;
        sup.mode_connected = 1'b0;
        link_losses++;
      end else begin
        r.poll_receive = 1'b1;
      end
    end
    r.connected = sup.mode_connected;
    r.rx_enable = sup.receive_enabled;
    r.speed_100 = sup.speed_flag;
    r.full_duplex = sup.duplex_flag;
    return r;
  endfunction

  task automatic send_tick(input logic idle, input logic [15:0] rd);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, rd, idle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    status_q.push_back(advance_supervisor(idle, rd));
    ticks_sent++;
  endtask

  // bias read data toward what the current step waits for
  task automatic random_tick();
    logic        idle;
    logic [15:0] rd;
    idle = ($urandom_range(99) < 75);
    rd = 16'($urandom_range(16'hFFFF));
    if ($urandom_range(99) >= 10) begin
      if (sup.mode_connected) rd[BMSR_LINK_BIT] = ($urandom_range(99) < 92);
      else if (sup.link_step == LS_WAIT_BMSR) rd[BMSR_LINK_BIT] = ($urandom_range(99) < 70);
      else if (sup.link_step == LS_WAIT_STATUS) rd[STS_LINK_BIT] = ($urandom_range(99) < 65);
    end
    send_tick(idle, rd);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] phy, input logic [15:0] sts,
                            input logic [15:0] ctl);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_PHY_ADDR;
    cfg_wdata <= phy;
    @(posedge clk);
    cfg_addr <= CFG_STATUS_REG;
    cfg_wdata <= sts;
    @(posedge clk);
    cfg_addr <= CFG_CONTROL_VAL;
    cfg_wdata <= ctl;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    setting.phy_address = phy[4:0];
    setting.status_reg_address = sts[4:0];
    setting.control_write_value = ctl;
    settings_used++;
  endtask

  task automatic test_link_sequence();
    send_tick(1'b0, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h0004);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'hFFFE);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h0003);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h0004);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'hFFFB);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'h0005);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'hFFFF);
    wait_for_results();
  endtask

  task automatic test_register_settings();
    write_regs(16'h0000, 16'h0000, 16'h0000);
    repeat (70) random_tick();
    wait_for_results();
    write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (70) random_tick();
    wait_for_results();
    repeat (3) begin
      write_regs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                 16'($urandom_range(16'hFFFF)));
      repeat (70) random_tick();
      wait_for_results();
    end
  endtask

  task automatic test_backpressure();
    write_regs(16'($urandom_range(31)), 16'($urandom_range(31)),
               16'($urandom_range(16'hFFFF)));
    stall_ask <= ~stall_ask;
    repeat (60) random_tick();
    wait_for_results();
  endtask

  task automatic test_steady_stream();
    gaps_on <= 1'b0;
    repeat (120) random_tick();
    wait_for_results();
    gaps_on <= 1'b1;
  endtask

  always @(posedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(gaps_on && $urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin : check_beats
    pls_result_t seen;
    pls_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[$bits(pls_result_t)-1:0];
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_tdata);
      end else begin
        want = status_q.pop_front();
        beats_checked++;
        if (seen.command_valid !== want.command_valid ||
            seen.mdio_command !== want.mdio_command ||
            seen.connected !== want.connected ||
            seen.rx_enable !== want.rx_enable ||
            seen.speed_100 !== want.speed_100 ||
            seen.full_duplex !== want.full_duplex ||
            seen.poll_receive !== want.poll_receive) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp vld=%b cmd=%h con=%b rx=%b spd=%b dup=%b poll=%b",
                     beats_checked, want.command_valid, want.mdio_command, want.connected,
                     want.rx_enable, want.speed_100, want.full_duplex, want.poll_receive,
                     "\n         got vld=%b cmd=%h con=%b rx=%b spd=%b dup=%b poll=%b",
                     seen.command_valid, seen.mdio_command, seen.connected,
                     seen.rx_enable, seen.speed_100, seen.full_duplex, seen.poll_receive);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_link_sequence();
    test_register_settings();
    test_backpressure();
    test_steady_stream();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0d expected beats never arrived", status_q.size());
      mismatches += status_q.size();
    end
    $display("covered %0d ticks, %0d beats checked, %0d link-ups, %0d link losses",
             ticks_sent, beats_checked, link_ups, link_losses);
    $display("over %0d register settings, with one long output hold-off", settings_used);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
